// ===== rtl/sorted_delay_message_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for sorted_delay_message_queue_top
// ----------------------------------------------------------------------------
`ifndef SORTED_DELAY_MESSAGE_QUEUE_TOP_ASSERT_SVH
`define SORTED_DELAY_MESSAGE_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SDMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdmq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmq_pkg
// Shared types and codes of the sorted delay message queue.
// ----------------------------------------------------------------------------
package sdmq_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned MSG_W  = 16;
  localparam int unsigned KIND_W = 2;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_PROCESS  = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_NONE    = 2'd2
  } kind_t;

  // Classified command as it sits in the queue between front and back.
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] trigger;
    logic [MSG_W-1:0]  message_id;
  } cmd_t;

endpackage

// ===== rtl/sdmq_front.sv =====
// ----------------------------------------------------------------------------
// sdmq_front
// Accepts input beats, computes the trigger time and queues the command.
// ----------------------------------------------------------------------------
module sdmq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [79:0]   s_tdata,   // now_ms[31:0], delay_ms[63:32], message_id[79:64]
  input  logic          s_tuser,   // op
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output sdmq_pkg::cmd_t cmd
);
  import sdmq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign s_tready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    in_cmd.op         = op_t'(s_tuser);
    in_cmd.now_ms     = s_tdata[31:0];
    in_cmd.trigger    = s_tdata[31:0] + s_tdata[63:32];  // wraps mod 2^32
    in_cmd.message_id = s_tdata[79:64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_cmd;
  end

endmodule

// ===== rtl/sdmq_back.sv =====
// ----------------------------------------------------------------------------
// sdmq_back
// Sorted entry list: shift-insert for schedule, head release for process,
// with a registered output stage.
// ----------------------------------------------------------------------------
module sdmq_back #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  sdmq_pkg::cmd_t                cmd,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // accepted[0], released_message[16:1]
  output logic [sdmq_pkg::KIND_W-1:0]   m_tuser,  // kind
  output logic                          m_tlast
);
  import sdmq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [TIME_W-1:0] entry_time [DEPTH];
  logic [MSG_W-1:0]  entry_message [DEPTH];
  logic [CW-1:0]     entry_count;

  logic [TIME_W-1:0] entry_time_next [DEPTH];
  logic [MSG_W-1:0]  entry_message_next [DEPTH];
  logic [DEPTH-1:0]  cell_sel;

  kind_t             out_kind;
  logic              out_accepted;
  logic [MSG_W-1:0]  out_msg;
  logic              out_last;

  logic out_free, is_sched, full, due0, due1, fire, do_insert, do_release;

  assign out_free   = !m_tvalid || m_tready;
  assign is_sched   = (cmd.op == OP_SCHEDULE);
  assign full       = (entry_count == CW'(DEPTH));
  assign due0       = (entry_count != '0) && (cmd.now_ms >= entry_time[0]);
  assign fire       = cmd_valid && out_free;
  assign do_insert  = fire && is_sched && !full;
  assign do_release = fire && !is_sched && due0;
  // a process command stays at the head until its final release
  assign cmd_ready  = out_free && (is_sched || !due0 || !due1);

  generate
    if (DEPTH > 1) begin : g_due1
      assign due1 = (entry_count > CW'(1)) && (cmd.now_ms >= entry_time[1]);
    end else begin : g_no_due1
      assign due1 = 1'b0;
    end
  endgenerate

  // sel marks cells at or past the insertion point (monotone along the list)
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              prev_sel;
    logic [TIME_W-1:0] prev_time, succ_time;
    logic [MSG_W-1:0]  prev_msg, succ_msg;

    assign cell_sel[g] = (CW'(g) >= entry_count) || (entry_time[g] > cmd.trigger);

    if (g == 0) begin : g_head
      assign prev_sel  = 1'b0;
      assign prev_time = entry_time[g];
      assign prev_msg  = entry_message[g];
    end else begin : g_body
      assign prev_sel  = cell_sel[g-1];
      assign prev_time = entry_time[g-1];
      assign prev_msg  = entry_message[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign succ_time = entry_time[g];
      assign succ_msg  = entry_message[g];
    end else begin : g_inner
      assign succ_time = entry_time[g+1];
      assign succ_msg  = entry_message[g+1];
    end

    always_comb begin
      entry_time_next[g]    = entry_time[g];
      entry_message_next[g] = entry_message[g];
      if (do_insert) begin
        if (prev_sel) begin
          entry_time_next[g]    = prev_time;
          entry_message_next[g] = prev_msg;
        end else if (cell_sel[g]) begin
          entry_time_next[g]    = cmd.trigger;
          entry_message_next[g] = cmd.message_id;
        end
      end else if (do_release) begin
        entry_time_next[g]    = succ_time;
        entry_message_next[g] = succ_msg;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_time[i]    <= entry_time_next[i];
      entry_message[i] <= entry_message_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (do_insert)       entry_count <= entry_count + CW'(1);
      else if (do_release) entry_count <= entry_count - CW'(1);
      if (fire)            m_tvalid <= 1'b1;
      else if (m_tready)   m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      priority if (is_sched) begin
        out_kind     <= KIND_ACK;
        out_accepted <= !full;
        out_msg      <= '0;
        out_last     <= 1'b1;
      end else if (due0) begin
        out_kind     <= KIND_RELEASE;
        out_accepted <= 1'b0;
        out_msg      <= entry_message[0];
        out_last     <= !due1;
      end else begin
        out_kind     <= KIND_NONE;
        out_accepted <= 1'b0;
        out_msg      <= '0;
        out_last     <= 1'b1;
      end
    end
  end

  assign m_tdata = {7'd0, out_msg, out_accepted};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// ===== rtl/sorted_delay_message_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_delay_message_queue_top
// Timer queue of message handles sorted by trigger time.
// ----------------------------------------------------------------------------
// A schedule beat (tuser 0) stores message_id with trigger now_ms + delay_ms
// (mod 2^32) behind all entries with an equal or earlier trigger and answers
// with one acknowledgement beat (accepted 0 when DEPTH entries are pending).
// A process beat (tuser 1) releases, oldest trigger first, every entry whose
// trigger is at or below now_ms (plain unsigned compare), one output beat
// each, or gives a single kind 2 beat when nothing is due; tlast closes the
// answer to every input beat. The back end handles one output beat per
// cycle while its single output register is free (empty or being taken),
// so a process answer, at least one beat long, holds the command queue head
// until its last release. Input beats go through a two-entry command queue,
// so each beat is registered in a queue slot and then in the output register.
// No clearing pass is needed after reset.
module sorted_delay_message_queue_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // now_ms[31:0], delay_ms[63:32], message_id[79:64]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // accepted[0], released_message[16:1], zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);
  import sdmq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sdmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sdmq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== rtl/sdmq_checker.sv =====
// ----------------------------------------------------------------------------
// sdmq_checker
// Port-level checks of the output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_delay_message_queue_top_assert.svh"

module sdmq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import sdmq_pkg::*;

  logic stalled;
  logic non_release;
  logic non_ack;

  assign stalled     = m_tvalid && !m_tready;
  assign non_release = m_tvalid && (m_tuser != KIND_RELEASE);
  assign non_ack     = m_tvalid && (m_tuser != KIND_ACK);

  // held beat keeps its payload
  `SDMQ_ASSERT_NEXT(a_out_hold, clk, rst, stalled,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "output beat changed while stalled")

  `SDMQ_ASSERT_NOW(a_kind_code, clk, rst, m_tvalid, m_tuser <= KIND_NONE,
    "undefined kind on output")

  // ack and nothing-due beats always close their answer and carry no handle
  `SDMQ_ASSERT_NOW(a_single_last, clk, rst, non_release,
    m_tlast && (m_tdata[16:1] == 16'd0),
    "single-beat answer without tlast or with a handle")

  `SDMQ_ASSERT_NOW(a_accept_ack, clk, rst, non_ack, !m_tdata[0],
    "accepted flag outside an acknowledgement")

endmodule

bind sorted_delay_message_queue_top sdmq_checker u_sdmq_checker (.*);
